### rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned RegWidth   = 16;
  localparam int unsigned StampWidth = 16;
  localparam int unsigned DistWidth  = 24;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] RegTriggerPeriod = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegEchoTimeout   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegStaleLimit    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegMinWidth      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegMaxWidth      = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegScale         = 3'd5;

  localparam logic [RegWidth-1:0] TriggerPeriodRst = 16'd100;
  localparam logic [RegWidth-1:0] EchoTimeoutRst   = 16'd30;
  localparam logic [RegWidth-1:0] StaleLimitRst    = 16'd300;
  localparam logic [RegWidth-1:0] MinWidthRst      = 16'd117;
  localparam logic [RegWidth-1:0] MaxWidthRst      = 16'd23323;
  localparam logic [RegWidth-1:0] ScaleRst         = 16'd1124;

  typedef struct packed {
    logic                 trigger_start;
    logic                 measuring;
    logic [DistWidth-1:0] distance;
    logic                 distance_ok;
  } result_t;

endpackage

### rtl/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// Configuration registers, ranging state and the state update per accepted item.
// ----------------------------------------------------------------------------
module uer_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uer_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [uer_pkg::RegWidth-1:0]       cfg_data_i,
  input  logic                               fire_i,
  input  logic                               operation_i,
  input  logic                               rise_seen_i,
  input  logic                               fall_seen_i,
  input  logic                               overrun_i,
  input  logic [uer_pkg::StampWidth-1:0]     rise_time_i,
  input  logic [uer_pkg::StampWidth-1:0]     fall_time_i,
  input  logic                               echo_high_i,
  output uer_pkg::result_t                   res_o
);

  logic [uer_pkg::RegWidth-1:0] period_q, timeout_q, stale_q, min_w_q, max_w_q, scale_q;

  logic [TIME_WIDTH-1:0] now_q, now_d, win_q, win_d, finish_q, finish_d, good_q, good_d;
  logic waiting_q, waiting_d, have_rise_q, have_rise_d, done_q, done_d, bad_q, bad_d;
  logic valid_q, valid_d;
  logic [uer_pkg::StampWidth-1:0] rise_stamp_q, rise_stamp_d, width_q, width_d;
  logic [uer_pkg::DistWidth-1:0]  dist_q, dist_d;

  logic [TIME_WIDTH-1:0] timeout_ext, period_ext, stale_ext;
  logic [2*uer_pkg::RegWidth-1:0] product;

  assign timeout_ext = TIME_WIDTH'(timeout_q);
  assign period_ext  = TIME_WIDTH'(period_q);
  assign stale_ext   = TIME_WIDTH'(stale_q);
  assign product     = (2*uer_pkg::RegWidth)'(width_q) * (2*uer_pkg::RegWidth)'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= uer_pkg::TriggerPeriodRst;
      timeout_q <= uer_pkg::EchoTimeoutRst;
      stale_q   <= uer_pkg::StaleLimitRst;
      min_w_q   <= uer_pkg::MinWidthRst;
      max_w_q   <= uer_pkg::MaxWidthRst;
      scale_q   <= uer_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        uer_pkg::RegTriggerPeriod: period_q  <= cfg_data_i;
        uer_pkg::RegEchoTimeout:   timeout_q <= cfg_data_i;
        uer_pkg::RegStaleLimit:    stale_q   <= cfg_data_i;
        uer_pkg::RegMinWidth:      min_w_q   <= cfg_data_i;
        uer_pkg::RegMaxWidth:      max_w_q   <= cfg_data_i;
        uer_pkg::RegScale:         scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic hr;
    logic acc;
    now_d        = now_q;
    win_d        = win_q;
    finish_d     = finish_q;
    good_d       = good_q;
    waiting_d    = waiting_q;
    have_rise_d  = have_rise_q;
    done_d       = done_q;
    bad_d        = bad_q;
    valid_d      = valid_q;
    rise_stamp_d = rise_stamp_q;
    width_d      = width_q;
    dist_d       = dist_q;
    hr           = have_rise_q;
    acc          = 1'b0;
    res_o.trigger_start = 1'b0;

    if (operation_i) begin
      now_d = now_q + TIME_WIDTH'(1);
      if (waiting_q) begin
        if (done_q) begin
          waiting_d = 1'b0;
          acc = !bad_q && ((finish_q - win_q) < timeout_ext)
                && (width_q >= min_w_q) && (width_q <= max_w_q);
          valid_d = acc;
          if (acc) begin
            dist_d = product[uer_pkg::DistWidth+7:8];
            good_d = finish_q;
          end
        end else if ((now_d - win_q) >= timeout_ext) begin
          waiting_d = 1'b0;
          valid_d   = 1'b0;
        end
      end
      if (!waiting_d && ((now_d - win_q) >= period_ext)) begin
        win_d = now_d;
        if (echo_high_i) begin
          valid_d = 1'b0;
        end else begin
          have_rise_d = 1'b0;
          done_d      = 1'b0;
          bad_d       = 1'b0;
          waiting_d   = 1'b1;
          res_o.trigger_start = 1'b1;
        end
      end
    end else if (waiting_q && !done_q) begin
      if (overrun_i) begin
        bad_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        if (rise_seen_i) begin
          if (have_rise_q) begin
            bad_d = 1'b1;
          end
          rise_stamp_d = rise_time_i;
          hr           = 1'b1;
          have_rise_d  = 1'b1;
        end
        if (fall_seen_i && hr) begin
          width_d  = fall_time_i - rise_stamp_d;
          finish_d = now_q;
          done_d   = 1'b1;
        end
      end
    end

    res_o.measuring   = waiting_d;
    res_o.distance_ok = valid_d && ((now_d - good_d) <= stale_ext);
    res_o.distance    = res_o.distance_ok ? dist_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      win_q        <= '0;
      finish_q     <= '0;
      good_q       <= '0;
      waiting_q    <= 1'b0;
      have_rise_q  <= 1'b0;
      done_q       <= 1'b0;
      bad_q        <= 1'b0;
      valid_q      <= 1'b0;
      rise_stamp_q <= '0;
      width_q      <= '0;
      dist_q       <= '0;
    end else if (fire_i) begin
      now_q        <= now_d;
      win_q        <= win_d;
      finish_q     <= finish_d;
      good_q       <= good_d;
      waiting_q    <= waiting_d;
      have_rise_q  <= have_rise_d;
      done_q       <= done_d;
      bad_q        <= bad_d;
      valid_q      <= valid_d;
      rise_stamp_q <= rise_stamp_d;
      width_q      <= width_d;
      dist_q       <= dist_d;
    end
  end

endmodule

### rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Echo ranging controller: trigger scheduling, echo pairing, timeout,
// width check, fixed-point distance and staleness flag.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  operation, capture flags, stamps, echo
//   out      output     out_valid_o/out_stall_i trigger_start, measuring, distance, ok
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; each transfer yields one registered result.
// The state update and the 16x16 distance multiply sit in the same cycle.
// Reset is asynchronous; the block is ready right after it.
// A two-entry output buffer absorbs stalls; in_stall_o rises only when both
// entries hold results.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [uer_pkg::RegWidth-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic                            rise_seen_i,
  input  logic                            fall_seen_i,
  input  logic                            overrun_i,
  input  logic [uer_pkg::StampWidth-1:0]  rise_time_i,
  input  logic [uer_pkg::StampWidth-1:0]  fall_time_i,
  input  logic                            echo_high_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            trigger_start_o,
  output logic                            measuring_o,
  output logic [uer_pkg::DistWidth-1:0]   distance_o,
  output logic                            distance_ok_o
);

  uer_pkg::result_t res, out_q, out_d, skid_q, skid_d;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic fire;

  assign in_stall_o = skid_valid_q;
  assign fire       = in_valid_i && !skid_valid_q;

  uer_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .operation_i (operation_i),
    .rise_seen_i (rise_seen_i),
    .fall_seen_i (fall_seen_i),
    .overrun_i   (overrun_i),
    .rise_time_i (rise_time_i),
    .fall_time_i (fall_time_i),
    .echo_high_i (echo_high_i),
    .res_o       (res)
  );

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = fire;
      end
    end else if (fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_start_o = out_q.trigger_start;
  assign measuring_o     = out_q.measuring;
  assign distance_o      = out_q.distance;
  assign distance_ok_o   = out_q.distance_ok;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_trigger_opens_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.trigger_start) |-> out_q.measuring)
    else $error("trigger reported without an open window");

  a_distance_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.distance_ok) |-> (out_q.distance == '0))
    else $error("distance shown while not ok");

  a_stalled_transfer_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transfer during output stall not captured");

endmodule
